// ----- rtl/pir_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pir_pkg
// Types, codes and the CRC-16/XMODEM byte update for the paged image receiver.
// ----------------------------------------------------------------------------
package pir_pkg;

   localparam int PAGE_SIZE_DEFAULT = 256;
   localparam logic [7:0] TIMEOUT_RESET = 8'd60;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_LOW_MASK = 16'h00FF;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_ERROR = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   typedef enum logic [2:0] {
      PH_COUNT = 3'd0,
      PH_LAST  = 3'd1,
      PH_DATA  = 3'd2,
      PH_CRC   = 3'd3,
      PH_DONE  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ST_BUSY     = 3'd0,
      ST_OK       = 3'd1,
      ST_CRC      = 3'd2,
      ST_TIMEOUT  = 3'd3,
      ST_FRAME    = 3'd4,
      ST_OVERRUN  = 3'd5,
      ST_OVERFLOW = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_byte;
      logic       frame_error;
      logic       overrun_error;
      logic       overflow_error;
   } req_item_type;

   typedef struct packed {
      logic        write_enable;
      logic [15:0] page_index;
      logic [7:0]  byte_offset;
      logic [7:0]  write_data;
      logic        send_ack;
      status_type  status;
      logic [15:0] running_crc;
   } rsp_item_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/pir_in_reg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pir_in_reg
// Input register: holds one request word until the core takes it.
// ----------------------------------------------------------------------------
module pir_in_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire pir_pkg::req_item_type req_item,
   input  wire logic                  take,
   output logic                       item_valid,
   output pir_pkg::req_item_type      item
);
   import pir_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         accept;

   assign req_stall  = valid_ff && !take;
   assign accept     = req_valid && !req_stall;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/pir_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pir_core
// Frame parser state, CRC accumulator, timeout counter and result word.
// ----------------------------------------------------------------------------
module pir_core #(
   parameter int PAGE_SIZE = pir_pkg::PAGE_SIZE_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire pir_pkg::req_item_type item,
   input  wire logic                  csr_we,
   input  wire logic [7:0]            csr_wdata,
   output pir_pkg::rsp_item_type      result
);
   import pir_pkg::*;

   localparam int BL_W = $clog2(PAGE_SIZE + 1);
   localparam int WP_W = $clog2(PAGE_SIZE);
   localparam int OW   = (WP_W > 8) ? WP_W : 8;
   localparam logic [15:0]     PAGE_SIZE_W  = 16'(PAGE_SIZE);
   localparam logic [BL_W-1:0] PAGE_SIZE_BL = BL_W'(PAGE_SIZE);
   localparam logic [BL_W-1:0] BL_TWO       = BL_W'(2);
   localparam logic [BL_W-1:0] BL_ONE       = BL_W'(1);
   localparam logic [BL_W-1:0] BL_ZERO      = '0;

   phase_type       phase_ff, phase_in;
   logic [BL_W-1:0] bl_ff, bl_in;
   logic [15:0]     total_ff, total_in;
   logic [15:0]     pages_ff, pages_in;
   logic [15:0]     lpl_ff, lpl_in;
   logic [WP_W-1:0] wpos_ff, wpos_in;
   logic [15:0]     crc_ff, crc_in;
   logic [7:0]      secs_ff, secs_in;
   logic [7:0]      timeout_ff;
   status_type      status_ff, status_in;

   logic [BL_W-1:0] bl_dec;
   logic [7:0]      secs_dec;
   logic [15:0]     lpl_raw;
   logic [15:0]     lpl_fix;
   logic [15:0]     pages_dec;
   logic            data_write;
   logic [OW-1:0]   off_wide;

   assign bl_dec     = (bl_ff == BL_ZERO) ? BL_ZERO : bl_ff - BL_ONE;
   assign secs_dec   = (secs_ff == 8'd0) ? 8'd0 : secs_ff - 8'd1;
   assign lpl_raw    = {lpl_ff[15:8], item.rx_byte};
   assign lpl_fix    = (lpl_raw == 16'd0 || lpl_raw > PAGE_SIZE_W) ? PAGE_SIZE_W : lpl_raw;
   assign pages_dec  = pages_ff - 16'd1;
   assign data_write = (phase_ff == PH_DATA) && (item.kind == KIND_BYTE);
   assign off_wide   = OW'(wpos_ff);

   // next state
   always_comb begin
      phase_in  = phase_ff;
      bl_in     = bl_ff;
      total_in  = total_ff;
      pages_in  = pages_ff;
      lpl_in    = lpl_ff;
      wpos_in   = wpos_ff;
      crc_in    = crc_ff;
      secs_in   = secs_ff;
      status_in = status_ff;
      if (phase_ff != PH_DONE) begin
         case (item.kind)
            KIND_ERROR: begin
               if (secs_ff == 8'd0) begin
                  status_in = ST_TIMEOUT;
                  phase_in  = PH_DONE;
               end else if (item.overflow_error) begin
                  status_in = ST_OVERFLOW;
                  phase_in  = PH_DONE;
               end else if (item.overrun_error) begin
                  status_in = ST_OVERRUN;
                  phase_in  = PH_DONE;
               end else if (item.frame_error) begin
                  status_in = ST_FRAME;
                  phase_in  = PH_DONE;
               end
            end
            KIND_TICK: begin
               secs_in = secs_dec;
               if (secs_dec == 8'd0) begin
                  status_in = ST_TIMEOUT;
                  phase_in  = PH_DONE;
               end
            end
            KIND_BYTE: begin
               secs_in = timeout_ff;
               case (phase_ff)
                  PH_COUNT: begin
                     if (bl_ff == BL_TWO) begin
                        total_in = {item.rx_byte, 8'h00};
                        bl_in    = BL_ONE;
                     end else begin
                        total_in = {total_ff[15:8], item.rx_byte};
                        bl_in    = BL_TWO;
                        phase_in = PH_LAST;
                     end
                  end
                  PH_LAST: begin
                     if (bl_ff == BL_TWO) begin
                        lpl_in = {item.rx_byte, 8'h00};
                        bl_in  = BL_ONE;
                     end else begin
                        lpl_in   = lpl_fix;
                        pages_in = total_ff;
                        wpos_in  = '0;
                        if (total_ff == 16'd0) begin
                           phase_in = PH_CRC;
                           bl_in    = BL_TWO;
                        end else begin
                           phase_in = PH_DATA;
                           bl_in    = (total_ff == 16'd1) ? lpl_fix[BL_W-1:0] : PAGE_SIZE_BL;
                        end
                     end
                  end
                  PH_DATA: begin
                     crc_in  = crc_byte(crc_ff, item.rx_byte);
                     wpos_in = wpos_ff + WP_W'(1);
                     bl_in   = bl_dec;
                     if (bl_dec == BL_ZERO) begin
                        pages_in = pages_dec;
                        wpos_in  = '0;
                        if (pages_dec == 16'd0) begin
                           phase_in = PH_CRC;
                           bl_in    = BL_TWO;
                        end else begin
                           bl_in = (pages_dec == 16'd1) ? lpl_ff[BL_W-1:0] : PAGE_SIZE_BL;
                        end
                     end
                  end
                  PH_CRC: begin
                     if (bl_ff == BL_TWO) begin
                        if (crc_ff[15:8] != item.rx_byte) begin
                           status_in = ST_CRC;
                           phase_in  = PH_DONE;
                        end else begin
                           bl_in = BL_ONE;
                        end
                     end else begin
                        if ((crc_ff & CRC_LOW_MASK) != {8'h00, item.rx_byte}) begin
                           status_in = ST_CRC;
                        end else begin
                           status_in = ST_OK;
                        end
                        phase_in = PH_DONE;
                        bl_in    = BL_ZERO;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // result word
   always_comb begin
      result = '0;
      result.status      = status_in;
      result.running_crc = crc_in;
      if (data_write) begin
         result.write_enable = 1'b1;
         result.page_index   = total_ff - pages_ff;
         result.byte_offset  = off_wide[7:0];
         result.write_data   = item.rx_byte;
         result.send_ack     = (bl_dec == BL_ZERO);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_COUNT;
         bl_ff      <= BL_TWO;
         total_ff   <= '0;
         pages_ff   <= '0;
         lpl_ff     <= '0;
         wpos_ff    <= '0;
         crc_ff     <= '0;
         secs_ff    <= TIMEOUT_RESET;
         timeout_ff <= TIMEOUT_RESET;
         status_ff  <= ST_BUSY;
      end else begin
         if (step) begin
            phase_ff  <= phase_in;
            bl_ff     <= bl_in;
            total_ff  <= total_in;
            pages_ff  <= pages_in;
            lpl_ff    <= lpl_in;
            wpos_ff   <= wpos_in;
            crc_ff    <= crc_in;
            secs_ff   <= secs_in;
            status_ff <= status_in;
         end
         if (csr_we) begin
            timeout_ff <= csr_wdata;
            secs_ff    <= csr_wdata;
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/paged_image_receiver_crc16.sv -----
// Path: a word accepted on req is held in the input register, then in the result register
// that drives rsp. Throughput: one word per cycle while rsp is not stalled; the frame
// state updates as a word moves between these two registers.
// Reset: synchronous, clears both registers' valid bits, returns the parser to the page
// count header and the timeout register to 60 seconds.
`default_nettype none
// ----------------------------------------------------------------------------
// paged_image_receiver_crc16
// Receives a paged firmware image from UART words and emits page writes.
// ----------------------------------------------------------------------------
module paged_image_receiver_crc16 #(
   parameter int PAGE_SIZE = pir_pkg::PAGE_SIZE_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_frame_error,
   input  wire logic        req_overrun_error,
   input  wire logic        req_overflow_error,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_write_enable,
   output logic [15:0]      rsp_page_index,
   output logic [7:0]       rsp_byte_offset,
   output logic [7:0]       rsp_write_data,
   output logic             rsp_send_ack,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_running_crc,
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata
);
   import pir_pkg::*;

   req_item_type req_item;
   req_item_type item;
   logic         item_valid;
   logic         take;
   logic         out_load;
   rsp_item_type result;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff, rsp_valid_in;

   assign req_item = '{kind: req_kind, rx_byte: req_rx_byte, frame_error: req_frame_error,
                       overrun_error: req_overrun_error, overflow_error: req_overflow_error};

   assign out_load = !rsp_valid_ff || !rsp_stall;
   assign take     = item_valid && out_load;

   pir_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   pir_core #(
      .PAGE_SIZE (PAGE_SIZE)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (take),
      .item      (item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .result    (result)
   );

   always_comb begin
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (out_load) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_enable = rsp_ff.write_enable;
   assign rsp_page_index   = rsp_ff.page_index;
   assign rsp_byte_offset  = rsp_ff.byte_offset;
   assign rsp_write_data   = rsp_ff.write_data;
   assign rsp_send_ack     = rsp_ff.send_ack;
   assign rsp_status       = rsp_ff.status;
   assign rsp_running_crc  = rsp_ff.running_crc;

   a_ack_with_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.send_ack) |-> rsp_ff.write_enable)
      else $error("ack without page write");

   a_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.write_enable) |-> (rsp_ff.status == ST_BUSY))
      else $error("page write after load finished");

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !take)
      else $error("result register overwritten while stalled");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (item_valid && !take))
      else $error("input stalled with free input register");

endmodule
`default_nettype wire

// ----- tb/paged_image_receiver_crc16_test.sv -----
// ----------------------------------------------------------------------------
// paged_image_receiver_crc16_test
// Drives one firmware upload frame (header, paged data with stray ticks and
// events, CRC tail or an early end) into the receiver. Every result word is
// compared with a cycle-free model of the frame parser, CRC and timeout.
// ----------------------------------------------------------------------------
module paged_image_receiver_crc16_test;
   import pir_pkg::*;

   localparam int PAGE_BYTES = 256;
   localparam int STALL_LIMIT = 2000;
   localparam logic [15:0] XMODEM_POLY = 16'h1021;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [2:0] NO_FLAGS = 3'b000;
   localparam logic [2:0] ALL_FLAGS = 3'b111;

   typedef enum {
      END_OK,
      END_CRC_HIGH,
      END_CRC_LOW,
      END_TIMEOUT_COUNT,
      END_TIMEOUT_ZERO,
      END_RX_ERROR
   } ending_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = KIND_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_frame_error = 1'b0;
   logic        req_overrun_error = 1'b0;
   logic        req_overflow_error = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_write_enable;
   logic [15:0] rsp_page_index;
   logic [7:0]  rsp_byte_offset;
   logic [7:0]  rsp_write_data;
   logic        rsp_send_ack;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_running_crc;
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = 8'h00;

   // receiver model state
   phase_type   rx_phase = PH_COUNT;
   logic [8:0]  count_left = 9'd2;
   logic [15:0] page_total = 16'h0000;
   logic [15:0] pages_remaining = 16'h0000;
   logic [15:0] last_len = 16'h0000;
   logic [7:0]  byte_pos = 8'h00;
   logic [15:0] image_crc = 16'h0000;
   logic [7:0]  secs_left = TIMEOUT_RESET;
   status_type  load_status = ST_BUSY;
   logic [7:0]  timeout_reg = TIMEOUT_RESET;

   rsp_item_type pending_reports[$];
   int unsigned  mismatches = 0;
   int unsigned  words_taken = 0;
   int unsigned  results_checked = 0;
   int unsigned  quiet_cycles = 0;
   int unsigned  page_budget = 6;
   logic [15:0]  declared_last = 16'h0000;
   logic         quiet_end = 1'b0;
   logic         req_calm = 1'b0;
   logic         rsp_calm = 1'b0;
   int unsigned  stall_run = 0;

   paged_image_receiver_crc16 #(.PAGE_SIZE(PAGE_BYTES)) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_rx_byte        (req_rx_byte),
      .req_frame_error    (req_frame_error),
      .req_overrun_error  (req_overrun_error),
      .req_overflow_error (req_overflow_error),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_write_enable   (rsp_write_enable),
      .rsp_page_index     (rsp_page_index),
      .rsp_byte_offset    (rsp_byte_offset),
      .rsp_write_data     (rsp_write_data),
      .rsp_send_ack       (rsp_send_ack),
      .rsp_status         (rsp_status),
      .rsp_running_crc    (rsp_running_crc),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] data);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb = acc[15] ^ data[i];
         acc = {acc[14:0], 1'b0} ^ (fb ? XMODEM_POLY : 16'h0000);
      end
      return acc;
   endfunction

   function automatic logic [8:0] current_page_len();
      return (pages_remaining == 16'd1) ? last_len[8:0] : 9'(PAGE_BYTES);
   endfunction

   task automatic end_load(input status_type st);
      load_status = st;
      rx_phase = PH_DONE;
   endtask

   task automatic track_receiver(input req_item_type w, output rsp_item_type r);
      r = '0;
      if (rx_phase != PH_DONE) begin
         if (w.kind == KIND_ERROR) begin
            if (secs_left == 8'd0) end_load(ST_TIMEOUT);
            else if (w.overflow_error) end_load(ST_OVERFLOW);
            else if (w.overrun_error) end_load(ST_OVERRUN);
            else if (w.frame_error) end_load(ST_FRAME);
         end else if (w.kind == KIND_TICK) begin
            if (secs_left != 8'd0) secs_left--;
            if (secs_left == 8'd0) end_load(ST_TIMEOUT);
         end else if (w.kind == KIND_BYTE) begin
            secs_left = timeout_reg;
            case (rx_phase)
               PH_COUNT: begin
                  if (count_left == 9'd2) begin
                     page_total = {w.rx_byte, 8'h00};
                     count_left = 9'd1;
                  end else begin
                     page_total[7:0] = w.rx_byte;
                     count_left = 9'd2;
                     rx_phase = PH_LAST;
                  end
               end
               PH_LAST: begin
                  if (count_left == 9'd2) begin
                     last_len = {w.rx_byte, 8'h00};
                     count_left = 9'd1;
                  end else begin
                     last_len[7:0] = w.rx_byte;
                     if (last_len == 16'd0 || last_len > PAGE_BYTES) last_len = 16'(PAGE_BYTES);
                     pages_remaining = page_total;
                     byte_pos = 8'h00;
                     if (pages_remaining == 16'd0) begin
                        rx_phase = PH_CRC;
                        count_left = 9'd2;
                     end else begin
                        rx_phase = PH_DATA;
                        count_left = current_page_len();
                     end
                  end
               end
               PH_DATA: begin
                  image_crc = crc_next(image_crc, w.rx_byte);
                  r.write_enable = 1'b1;
                  r.page_index = page_total - pages_remaining;
                  r.byte_offset = byte_pos;
                  r.write_data = w.rx_byte;
                  byte_pos++;
                  if (count_left != 9'd0) count_left--;
                  if (count_left == 9'd0) begin
                     r.send_ack = 1'b1;
                     pages_remaining--;
                     byte_pos = 8'h00;
                     if (pages_remaining == 16'd0) begin
                        rx_phase = PH_CRC;
                        count_left = 9'd2;
                     end else begin
                        count_left = current_page_len();
                     end
                  end
               end
               PH_CRC: begin
                  if (count_left == 9'd2) begin
                     if (image_crc[15:8] != w.rx_byte) end_load(ST_CRC);
                     else count_left = 9'd1;
                  end else begin
                     if (image_crc[7:0] != w.rx_byte) end_load(ST_CRC);
                     else end_load(ST_OK);
                     count_left = 9'd0;
                  end
               end
               default: ;
            endcase
         end
      end
      r.status = load_status;
      r.running_crc = image_crc;
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // result check, model update and watchdog, all on the sampling edge
   always @(posedge clock) begin
      rsp_item_type want;
      req_item_type word;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_reports.size() == 0) begin
               $error("result with no word waiting: status %0d", rsp_status);
               mismatches++;
            end else begin
               want = pending_reports.pop_front();
               check_field("write_enable", want.write_enable, rsp_write_enable);
               check_field("page_index", want.page_index, rsp_page_index);
               check_field("byte_offset", want.byte_offset, rsp_byte_offset);
               check_field("write_data", want.write_data, rsp_write_data);
               check_field("send_ack", want.send_ack, rsp_send_ack);
               check_field("status", want.status, rsp_status);
               check_field("running_crc", want.running_crc, rsp_running_crc);
               results_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            word = {req_kind, req_rx_byte, req_frame_error, req_overrun_error,
                    req_overflow_error};
            track_receiver(word, want);
            pending_reports.push_back(want);
            words_taken++;
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT) begin
               $display("simulation failed");
               $finish;
            end
         end
      end
   end

   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) rsp_calm = !rsp_calm;
      if (quiet_end) begin
         stall_run = 0;
      end else if (stall_run == 0 && !rsp_calm && $urandom_range(0, 5) == 0) begin
         stall_run = $urandom_range(1, 7);
      end
      rsp_stall = (stall_run != 0);
      if (stall_run != 0) stall_run--;
   end

   // caller must follow with another send or drop req_valid in the same step
   task automatic send_word(input logic [1:0] kind, input logic [7:0] data,
                            input logic [2:0] flags);
      if ($urandom_range(0, 49) == 0) req_calm = !req_calm;
      if (!quiet_end && !req_calm && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_kind = kind;
      req_rx_byte = data;
      {req_overflow_error, req_overrun_error, req_frame_error} = flags;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] data);
      send_word(KIND_BYTE, data, 3'($urandom_range(0, 7)));
   endtask

   task automatic send_noise();
      case ($urandom_range(0, 2))
         0: begin
            if (secs_left > 8'd1) send_word(KIND_TICK, 8'($urandom), 3'($urandom));
            else send_word(KIND_UNUSED, 8'($urandom), 3'($urandom));
         end
         1: send_word(KIND_ERROR, 8'($urandom), NO_FLAGS);
         default: send_word(KIND_UNUSED, 8'($urandom), 3'($urandom));
      endcase
   endtask

   task automatic write_timeout(input logic [7:0] value);
      req_valid = 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      timeout_reg = value;
      secs_left = value;
   endtask

   task automatic test_events_before_header();
      write_timeout(8'd255);
      send_word(KIND_TICK, 8'h00, NO_FLAGS);
      send_word(KIND_UNUSED, 8'hFF, ALL_FLAGS);
      send_word(KIND_ERROR, 8'hFF, NO_FLAGS);
      send_word(KIND_TICK, 8'hFF, ALL_FLAGS);
      send_word(KIND_UNUSED, 8'h00, NO_FLAGS);
   endtask

   task automatic test_header();
      logic [15:0] declared;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) declared = 16'd0;
      else if (pick == 1) declared = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(256, 65534));
      else declared = 16'($urandom_range(4, 6));
      page_budget = (declared > 16'd6) ? 5 : 6;
      case ($urandom_range(0, 5))
         0: declared_last = 16'd0;
         1: declared_last = 16'd1;
         2: declared_last = 16'(PAGE_BYTES);
         3: declared_last = 16'(PAGE_BYTES + 1);
         4: declared_last = 16'hFFFF;
         default: declared_last = 16'($urandom_range(2, PAGE_BYTES - 1));
      endcase
      send_byte(declared[15:8]);
      send_byte(declared[7:0]);
      send_byte(declared_last[15:8]);
      send_byte(declared_last[7:0]);
      write_timeout(8'd1);
   endtask

   task automatic test_data_extremes();
      logic [7:0] corner_bytes[4];
      corner_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01};
      foreach (corner_bytes[i]) begin
         if (rx_phase == PH_DATA) send_byte(corner_bytes[i]);
      end
   endtask

   task automatic test_random_pages();
      logic [15:0] pages_before;
      logic [7:0]  next_timeout;
      while (rx_phase == PH_DATA && page_total - pages_remaining < page_budget) begin
         pages_before = pages_remaining;
         if ($urandom_range(0, 8) == 0) send_noise();
         else send_byte(8'($urandom));
         if (pages_remaining != pages_before && $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 3))
               0: next_timeout = 8'd1;
               1: next_timeout = 8'd255;
               default: next_timeout = 8'($urandom_range(2, 254));
            endcase
            write_timeout(next_timeout);
         end
      end
   endtask

   task automatic test_load_ending();
      ending_type how;
      logic [7:0] flip;
      int unsigned pick;
      flip = 8'($urandom_range(1, 255));
      if (rx_phase == PH_CRC) begin
         pick = $urandom_range(0, 9);
         case (pick)
            5: how = END_CRC_HIGH;
            6: how = END_CRC_LOW;
            7: how = END_TIMEOUT_COUNT;
            8: how = END_TIMEOUT_ZERO;
            9: how = END_RX_ERROR;
            default: how = END_OK;
         endcase
      end else begin
         case ($urandom_range(0, 2))
            0: how = END_TIMEOUT_COUNT;
            1: how = END_TIMEOUT_ZERO;
            default: how = END_RX_ERROR;
         endcase
      end
      case (how)
         END_OK: begin
            send_byte(image_crc[15:8]);
            send_byte(image_crc[7:0]);
         end
         END_CRC_HIGH: send_byte(image_crc[15:8] ^ flip);
         END_CRC_LOW: begin
            send_byte(image_crc[15:8]);
            send_byte(image_crc[7:0] ^ flip);
         end
         END_TIMEOUT_COUNT: begin
            write_timeout(8'($urandom_range(1, 4)));
            while (rx_phase != PH_DONE) send_word(KIND_TICK, 8'($urandom), 3'($urandom));
         end
         END_TIMEOUT_ZERO: begin
            write_timeout(8'd0);
            if ($urandom_range(0, 1)) send_word(KIND_TICK, 8'($urandom), 3'($urandom));
            else send_word(KIND_ERROR, 8'($urandom), 3'($urandom));
         end
         default: send_word(KIND_ERROR, 8'($urandom), 3'($urandom_range(1, 7)));
      endcase
   endtask

   task automatic test_after_finish();
      quiet_end = 1'b1;
      write_timeout(8'($urandom));
      repeat (20) send_word(2'($urandom), 8'($urandom), 3'($urandom));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_events_before_header();
      test_header();
      test_data_extremes();
      test_random_pages();
      test_load_ending();
      test_after_finish();
      req_valid = 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      $display("covered %0d words, %0d results checked, %0d of %0d declared pages written",
               words_taken, results_checked, page_total - pages_remaining, page_total);
      $display("last page field %0h, load ended as %s, crc %04h",
               declared_last, load_status.name(), image_crc);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/pir_pkg.sv
rtl/pir_in_reg.sv
rtl/pir_core.sv
rtl/paged_image_receiver_crc16.sv
tb/paged_image_receiver_crc16_test.sv
